[src/gcsp_pkg.sv]
// Shared types, codes and grid helpers of the grid congestion shortest-path block.
package gcsp_pkg;

  // Fixed field widths
  localparam int ID_W   = 6;
  localparam int LEN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int DIM_W  = 4;
  localparam int DIM_MAX = 8;
  // Weight numerator len*(cap+2*cars)*256 and denominator speed*cap
  localparam int FAC_W  = 10;
  localparam int PROD_W = LEN_W + FAC_W;
  localparam int FRAC_W = 8;
  localparam int NUM_W  = PROD_W + FRAC_W;
  localparam int DEN_W  = 2 * BYTE_W;
  localparam int ROAD_DATA_W = LEN_W + 2 * BYTE_W;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CAR   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOPATH  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // Road directions
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // Configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] node;
  } target_t;

  // Grid dimension as used: clamped to 1..8
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(DIM_MAX)) r = DIM_W'(DIM_MAX);
    return r;
  endfunction

  // Neighbour of a node in one direction; ok is low off the grid
  function automatic target_t road_target(input logic [ID_W-1:0] node,
                                          input logic [1:0] dir,
                                          input logic [DIM_W-1:0] w,
                                          input logic [DIM_W-1:0] h,
                                          input logic [ID_W:0] n);
    logic [2:0]  y;
    logic [ID_W:0] yw;
    logic [ID_W:0] x;
    logic [ID_W:0] t;
    logic [ID_W:0] w7;
    target_t r;
    w7 = (ID_W+1)'(w);
    // row index by compare against multiples of the width
    y = '0;
    for (int k = 1; k < DIM_MAX; k++) begin
      if ({1'b0, node} >= (ID_W+1)'(k) * w7) y = y + 3'd1;
    end
    yw = (ID_W+1)'(y) * w7;
    x  = {1'b0, node} - yw;
    r.ok = 1'b1;
    t = '0;
    case (dir)
      DIR_RIGHT: begin
        r.ok = (x + (ID_W+1)'(1)) < w7;
        t = {1'b0, node} + (ID_W+1)'(1);
      end
      DIR_LEFT: begin
        r.ok = (x != '0);
        t = {1'b0, node} - (ID_W+1)'(1);
      end
      DIR_DOWN: begin
        r.ok = ((ID_W+1)'(y) + (ID_W+1)'(1)) < (ID_W+1)'(h);
        t = {1'b0, node} + w7;
      end
      default: begin
        r.ok = (y != '0);
        t = {1'b0, node} - w7;
      end
    endcase
    if (t >= n || {1'b0, node} >= n) r.ok = 1'b0;
    r.node = t[ID_W-1:0];
    return r;
  endfunction

endpackage

[src/gcsp_if.sv]
// Valid/ready channel interfaces for the input and result beats.
interface gcsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [gcsp_pkg::ID_W-1:0]   road_from;
  logic [1:0]                  road_dir;
  logic [gcsp_pkg::LEN_W-1:0]  road_length;
  logic [gcsp_pkg::BYTE_W-1:0] road_speed;
  logic [gcsp_pkg::BYTE_W-1:0] road_capacity;
  logic [gcsp_pkg::BYTE_W-1:0] road_cars;
  logic [gcsp_pkg::ID_W-1:0]   path_start;
  logic [gcsp_pkg::ID_W-1:0]   path_goal;

  modport source(output valid, operation, road_from, road_dir, road_length, road_speed,
                 road_capacity, road_cars, path_start, path_goal, input ready);
  modport sink(input valid, operation, road_from, road_dir, road_length, road_speed,
               road_capacity, road_cars, path_start, path_goal, output ready);
endinterface

interface gcsp_out_if;
  logic                      valid;
  logic                      ready;
  logic [gcsp_pkg::ID_W-1:0] path_node;
  logic [1:0]                status;
  logic                      last;

  modport source(output valid, path_node, status, last, input ready);
  modport sink(input valid, path_node, status, last, output ready);
endinterface

[src/grid_congestion_shortest_path.sv]
// Top level: road table, Dijkstra sequencer and result register.
// A road write or a clear passes through decode and emit, adding a car also a car update state. A path query
// settles one node per round: a scan over the node distance memory, one entry per cycle,
// then for each usable road from that node a weight from the bit-serial weight divider and a
// relaxation step. The path is then walked back through the predecessor memory, one node per
// walk and wait state pair, and sent start first, one beat per result, each beat passing the
// read, wait and emit states and then the output register.
// The input takes a new item only when the sequencer is idle; the last result may still
// wait in the output register. No clearing pass is needed after reset.
module grid_congestion_shortest_path #(
  parameter int MAX_NODES  = 64,
  parameter int DIST_WIDTH = 40
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [gcsp_pkg::DIM_W-1:0] cfg_data,
  gcsp_in_if.sink                    in_ch,
  gcsp_out_if.source                 out_ch
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int ROAD_N = 4 * MAX_NODES;
  localparam int ROAD_W = NODE_W + 2;
  localparam int CNT_W  = NODE_W + 1;
  localparam int SUM_W  = DIST_WIDTH + 1;
  localparam int N_W    = gcsp_pkg::ID_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CAR_WAIT, S_SCAN, S_PICK, S_ROAD, S_RLOAD, S_MUL, S_DIV,
    S_RELAX, S_WALK, S_WALK_WAIT, S_PRD, S_PWAIT, S_EMIT
  } state_t;

  state_t state;
  state_t em_ret;

  // configuration
  logic [gcsp_pkg::DIM_W-1:0] grid_w, grid_h;
  logic [gcsp_pkg::DIM_W-1:0] w_e, h_e;
  logic [N_W-1:0]             n_prod, n_cnt;

  // latched input beat
  logic [1:0]                  op_r;
  logic [gcsp_pkg::ID_W-1:0]   from_r, start_r, goal_r;
  logic [1:0]                  dir_r;
  logic [gcsp_pkg::LEN_W-1:0]  len_r;
  logic [gcsp_pkg::BYTE_W-1:0] spd_r, cap_r, cars_r;

  // per-entry flags
  logic [ROAD_N-1:0]    present, car_valid;
  logic [MAX_NODES-1:0] settled, reached;

  // search registers
  logic [N_W-1:0]        scan_idx;
  logic                  found;
  logic [NODE_W-1:0]     best_idx, u, v;
  logic [DIST_WIDTH-1:0] best_dist, du, dv;
  logic [1:0]            dir_c;
  logic [gcsp_pkg::PROD_W-1:0] t1;
  logic [gcsp_pkg::DEN_W-1:0]  den;

  // path walk and emission
  logic [NODE_W-1:0] cur, pidx, em_node;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        em_status;
  logic              em_last;

  // result register
  logic                       out_valid, out_last;
  logic [gcsp_pkg::ID_W-1:0]  out_node;
  logic [1:0]                 out_status;
  logic                       slot_free;

  // memory ports
  logic                           road_we, car_we, dist_we, pred_we, pbuf_we;
  logic [ROAD_W-1:0]              road_waddr, road_raddr, car_waddr, car_raddr;
  logic [gcsp_pkg::ROAD_DATA_W-1:0] road_wdata, road_rdata;
  logic [gcsp_pkg::BYTE_W-1:0]    car_wdata, car_rdata;
  logic [NODE_W-1:0]              dist_waddr, dist_raddr, pred_waddr, pred_raddr;
  logic [NODE_W-1:0]              pbuf_waddr, pbuf_raddr;
  logic [DIST_WIDTH-1:0]          dist_wdata, dist_rdata;
  logic [NODE_W-1:0]              pred_wdata, pred_rdata, pbuf_wdata, pbuf_rdata;

  // divider
  logic                         div_start, div_done;
  logic [gcsp_pkg::NUM_W-1:0]   div_quot;

  // combinational helpers
  gcsp_pkg::target_t       tgt_from, tgt_u;
  logic [ROAD_W-1:0]       r_from, r_u;
  logic [NODE_W-1:0]       vt, prev_idx, start_i;
  logic                    road_use, cand;
  logic [gcsp_pkg::BYTE_W-1:0] cap_e, spd_e, cars_e, car_old;
  logic [gcsp_pkg::LEN_W-1:0]  rd_len;
  logic [gcsp_pkg::BYTE_W-1:0] rd_spd, rd_cap;
  logic [SUM_W-1:0]        sum;
  logic [DIST_WIDTH-1:0]   nd;
  logic                    improve;

  // grid size in use
  assign w_e    = gcsp_pkg::clamp_dim(grid_w);
  assign h_e    = gcsp_pkg::clamp_dim(grid_h);
  assign n_prod = N_W'(w_e) * N_W'(h_e);
  assign n_cnt  = (n_prod > N_W'(MAX_NODES)) ? N_W'(MAX_NODES) : n_prod;

  assign tgt_from = gcsp_pkg::road_target(from_r, dir_r, w_e, h_e, n_cnt);
  assign tgt_u    = gcsp_pkg::road_target(gcsp_pkg::ID_W'(u), dir_c, w_e, h_e, n_cnt);
  assign r_from   = {from_r[NODE_W-1:0], dir_r};
  assign r_u      = {u, dir_c};
  assign vt       = tgt_u.node[NODE_W-1:0];
  assign road_use = present[r_u] && tgt_u.ok && !settled[vt];
  assign start_i  = start_r[NODE_W-1:0];

  // min scan: entry read last cycle is compared now
  assign prev_idx = NODE_W'(scan_idx - N_W'(1));
  assign cand = (scan_idx != '0) && reached[prev_idx] && !settled[prev_idx] &&
                (!found || dist_rdata < best_dist);

  // road record fields and effective values
  assign {rd_len, rd_spd, rd_cap} = road_rdata;
  assign cap_e   = (rd_cap == '0) ? gcsp_pkg::BYTE_W'(1) : rd_cap;
  assign spd_e   = (rd_spd == '0) ? gcsp_pkg::BYTE_W'(1) : rd_spd;
  assign cars_e  = car_valid[r_u] ? car_rdata : '0;
  assign car_old = car_valid[r_from] ? car_rdata : '0;

  // relaxation with saturation
  assign sum     = {1'b0, du} + SUM_W'(div_quot);
  assign nd      = sum[DIST_WIDTH] ? '1 : sum[DIST_WIDTH-1:0];
  assign improve = !reached[v] || (nd < dv);

  assign slot_free = !out_valid || out_ch.ready;

  // memory port control
  always_comb begin
    road_we    = 1'b0;
    road_waddr = r_from;
    road_wdata = {len_r, spd_r, cap_r};
    road_raddr = r_u;
    car_we     = 1'b0;
    car_waddr  = r_from;
    car_wdata  = cars_r;
    car_raddr  = (state == S_DECODE) ? r_from : r_u;
    dist_we    = 1'b0;
    dist_waddr = v;
    dist_wdata = nd;
    dist_raddr = (state == S_SCAN) ? scan_idx[NODE_W-1:0] : vt;
    pred_we    = 1'b0;
    pred_waddr = v;
    pred_wdata = u;
    pred_raddr = cur;
    pbuf_we    = 1'b0;
    pbuf_waddr = cnt[NODE_W-1:0];
    pbuf_wdata = cur;
    pbuf_raddr = pidx;
    div_start  = 1'b0;
    case (state)
      S_DECODE: begin
        if (op_r == gcsp_pkg::OP_WRITE && tgt_from.ok) begin
          road_we = 1'b1;
          car_we  = 1'b1;
        end
        if (op_r == gcsp_pkg::OP_QUERY) begin
          dist_waddr = start_i;
          dist_wdata = '0;
          pred_waddr = start_i;
          pred_wdata = start_i;
          if ({1'b0, start_r} < n_cnt && {1'b0, goal_r} < n_cnt) begin
            dist_we = 1'b1;
            pred_we = 1'b1;
          end
        end
      end
      S_CAR_WAIT: begin
        car_we    = (car_old != '1);
        car_wdata = car_old + gcsp_pkg::BYTE_W'(1);
      end
      S_MUL:   div_start = 1'b1;
      S_RELAX: begin
        dist_we = improve;
        pred_we = improve;
      end
      S_WALK:  pbuf_we = 1'b1;
      default: ;
    endcase
  end

  // sequencer, flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      grid_w    <= gcsp_pkg::DIM_W'(gcsp_pkg::DIM_MAX);
      grid_h    <= gcsp_pkg::DIM_W'(gcsp_pkg::DIM_MAX);
      present   <= '0;
      car_valid <= '0;
      settled   <= '0;
      reached   <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
      em_ret    <= S_IDLE;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gcsp_pkg::CFG_GRID_WIDTH) grid_w <= cfg_data;
        else grid_h <= cfg_data;
      end
      // result beat stays until the sink takes it
      out_valid <= (state == S_EMIT && slot_free) || (out_valid && !out_ch.ready);

      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= in_ch.operation;
            from_r  <= in_ch.road_from;
            dir_r   <= in_ch.road_dir;
            len_r   <= in_ch.road_length;
            spd_r   <= in_ch.road_speed;
            cap_r   <= in_ch.road_capacity;
            cars_r  <= in_ch.road_cars;
            start_r <= in_ch.path_start;
            goal_r  <= in_ch.path_goal;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          em_node <= '0;
          em_last <= 1'b1;
          em_ret  <= S_IDLE;
          case (op_r)
            gcsp_pkg::OP_CLEAR: begin
              car_valid <= '0;
              em_status <= gcsp_pkg::ST_OK;
              state     <= S_EMIT;
            end
            gcsp_pkg::OP_QUERY: begin
              if ({1'b0, start_r} < n_cnt && {1'b0, goal_r} < n_cnt) begin
                settled   <= '0;
                reached   <= {{(MAX_NODES-1){1'b0}}, 1'b1} << start_i;
                scan_idx  <= '0;
                found     <= 1'b0;
                em_status <= gcsp_pkg::ST_OK;
                state     <= S_SCAN;
              end else begin
                em_status <= gcsp_pkg::ST_OUTSIDE;
                state     <= S_EMIT;
              end
            end
            default: begin
              if (!tgt_from.ok) begin
                em_status <= gcsp_pkg::ST_OUTSIDE;
                state     <= S_EMIT;
              end else if (op_r == gcsp_pkg::OP_WRITE) begin
                present[r_from]   <= 1'b1;
                car_valid[r_from] <= 1'b1;
                em_status         <= gcsp_pkg::ST_OK;
                state             <= S_EMIT;
              end else if (present[r_from]) begin
                em_status <= gcsp_pkg::ST_OK;
                state     <= S_CAR_WAIT;
              end else begin
                em_status <= gcsp_pkg::ST_OK;
                state     <= S_EMIT;
              end
            end
          endcase
        end
        S_CAR_WAIT: begin
          car_valid[r_from] <= 1'b1;
          state <= S_EMIT;
        end
        S_SCAN: begin
          if (cand) begin
            found     <= 1'b1;
            best_idx  <= prev_idx;
            best_dist <= dist_rdata;
          end
          if (scan_idx == n_cnt) state <= S_PICK;
          else scan_idx <= scan_idx + N_W'(1);
        end
        S_PICK: begin
          if (!found) begin
            em_node   <= '0;
            em_status <= gcsp_pkg::ST_NOPATH;
            em_last   <= 1'b1;
            em_ret    <= S_IDLE;
            state     <= S_EMIT;
          end else begin
            settled[best_idx] <= 1'b1;
            u     <= best_idx;
            du    <= best_dist;
            dir_c <= gcsp_pkg::DIR_RIGHT;
            if (best_idx == goal_r[NODE_W-1:0]) begin
              cur   <= best_idx;
              cnt   <= '0;
              state <= S_WALK;
            end else begin
              state <= S_ROAD;
            end
          end
        end
        S_ROAD: begin
          if (road_use) begin
            v     <= vt;
            state <= S_RLOAD;
          end else if (dir_c == gcsp_pkg::DIR_UP) begin
            scan_idx <= '0;
            found    <= 1'b0;
            state    <= S_SCAN;
          end else begin
            dir_c <= dir_c + 2'd1;
          end
        end
        S_RLOAD: begin
          t1    <= rd_len * (gcsp_pkg::FAC_W'(cap_e) + {1'b0, cars_e, 1'b0});
          den   <= spd_e * cap_e;
          dv    <= dist_rdata;
          state <= S_MUL;
        end
        S_MUL: state <= S_DIV;
        S_DIV: if (div_done) state <= S_RELAX;
        S_RELAX: begin
          if (improve) reached[v] <= 1'b1;
          if (dir_c == gcsp_pkg::DIR_UP) begin
            scan_idx <= '0;
            found    <= 1'b0;
            state    <= S_SCAN;
          end else begin
            dir_c <= dir_c + 2'd1;
            state <= S_ROAD;
          end
        end
        S_WALK: begin
          cnt <= cnt + CNT_W'(1);
          if (cur == start_i || (cnt + CNT_W'(1)) == CNT_W'(MAX_NODES)) begin
            pidx  <= cnt[NODE_W-1:0];
            state <= S_PRD;
          end else begin
            state <= S_WALK_WAIT;
          end
        end
        S_WALK_WAIT: begin
          cur   <= pred_rdata;
          state <= S_WALK;
        end
        S_PRD: state <= S_PWAIT;
        S_PWAIT: begin
          em_node   <= pbuf_rdata;
          em_status <= gcsp_pkg::ST_OK;
          em_last   <= (pidx == '0);
          em_ret    <= (pidx == '0) ? S_IDLE : S_PRD;
          pidx      <= pidx - NODE_W'(1);
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_node   <= gcsp_pkg::ID_W'(em_node);
            out_status <= em_status;
            out_last   <= em_last;
            state      <= em_ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready      = (state == S_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.path_node = out_node;
  assign out_ch.status    = out_status;
  assign out_ch.last      = out_last;

  gcsp_ram #(.WIDTH(gcsp_pkg::ROAD_DATA_W), .DEPTH(ROAD_N)) u_road_ram (
    .clk(clk), .we(road_we), .waddr(road_waddr), .wdata(road_wdata),
    .raddr(road_raddr), .rdata(road_rdata)
  );

  gcsp_ram #(.WIDTH(gcsp_pkg::BYTE_W), .DEPTH(ROAD_N)) u_car_ram (
    .clk(clk), .we(car_we), .waddr(car_waddr), .wdata(car_wdata),
    .raddr(car_raddr), .rdata(car_rdata)
  );

  gcsp_ram #(.WIDTH(DIST_WIDTH), .DEPTH(MAX_NODES)) u_dist_ram (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );

  gcsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_pred_ram (
    .clk(clk), .we(pred_we), .waddr(pred_waddr), .wdata(pred_wdata),
    .raddr(pred_raddr), .rdata(pred_rdata)
  );

  gcsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_pbuf_ram (
    .clk(clk), .we(pbuf_we), .waddr(pbuf_waddr), .wdata(pbuf_wdata),
    .raddr(pbuf_raddr), .rdata(pbuf_rdata)
  );

  gcsp_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({t1, {gcsp_pkg::FRAC_W{1'b0}}}), .den(den),
    .done(div_done), .quot(div_quot)
  );

  // an accepted beat always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state != S_IDLE)
    else $error("sequencer stayed idle after an accepted beat");

  // only reached nodes are ever settled
  a_settled_reached: assert property (@(posedge clk) disable iff (rst)
    (settled & ~reached) == '0)
    else $error("settled node was never reached");

  // the picked node is reached and still open
  a_pick_open: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK && found |-> reached[best_idx] && !settled[best_idx])
    else $error("scan picked a closed or unreached node");

endmodule

[src/gcsp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gcsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[src/gcsp_div.sv]
// Restoring divider, one quotient bit per cycle, for the road weight.
module gcsp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gcsp_pkg::NUM_W-1:0] num,
  input  logic [gcsp_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [gcsp_pkg::NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(gcsp_pkg::NUM_W + 1);

  logic                       running;
  logic [CNT_W-1:0]           cnt;
  logic [gcsp_pkg::DEN_W-1:0] rem;
  logic [gcsp_pkg::DEN_W-1:0] den_r;
  logic [gcsp_pkg::DEN_W:0]   trial;
  logic                       qbit;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem, quot[gcsp_pkg::NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        den_r   <= den;
        quot    <= num;
      end else if (running) begin
        rem  <= qbit ? gcsp_pkg::DEN_W'(trial - {1'b0, den_r})
                     : trial[gcsp_pkg::DEN_W-1:0];
        quot <= {quot[gcsp_pkg::NUM_W-2:0], qbit};
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(gcsp_pkg::NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

[tb/gcsp_route_checker.sv]
// Route checker: watches both channels, predicts the grid router's results and compares them.
module gcsp_route_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [gcsp_pkg::DIM_W-1:0] cfg_data,
  gcsp_in_if.sink                    in_mon,
  gcsp_out_if.sink                   out_mon,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 64;
  localparam int DW = 40;
  localparam logic [DW-1:0] DIST_SAT = {DW{1'b1}};

  typedef struct packed {
    logic [gcsp_pkg::ID_W-1:0] node;
    logic [1:0]                status;
    logic                      last;
  } route_beat_t;

  // Model of the road table
  logic [gcsp_pkg::DIM_W-1:0]  grid_w, grid_h;
  logic                        road_on   [NODES*4];
  logic [gcsp_pkg::LEN_W-1:0]  road_len  [NODES*4];
  logic [gcsp_pkg::BYTE_W-1:0] road_spd  [NODES*4];
  logic [gcsp_pkg::BYTE_W-1:0] road_cap  [NODES*4];
  logic [gcsp_pkg::BYTE_W-1:0] road_cnt  [NODES*4];

  route_beat_t expected_route[$];

  assign pending = expected_route.size();

  function automatic int used_dim(logic [gcsp_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return int'(v);
  endfunction

  function automatic int grid_nodes();
    return used_dim(grid_w) * used_dim(grid_h);
  endfunction

  // Neighbour id or -1 off the grid
  function automatic int neighbour(int node, logic [1:0] dir);
    int w, h, x, y, t;
    w = used_dim(grid_w);
    h = used_dim(grid_h);
    if (node >= grid_nodes()) return -1;
    x = node % w;
    y = node / w;
    case (dir)
      gcsp_pkg::DIR_RIGHT: begin
        if (x + 1 >= w) return -1;
        t = node + 1;
      end
      gcsp_pkg::DIR_LEFT: begin
        if (x == 0) return -1;
        t = node - 1;
      end
      gcsp_pkg::DIR_DOWN: begin
        if (y + 1 >= h) return -1;
        t = node + w;
      end
      default: begin
        if (y == 0) return -1;
        t = node - w;
      end
    endcase
    if (t >= grid_nodes()) return -1;
    return t;
  endfunction

  function automatic logic [63:0] travel_time(int r);
    logic [63:0] cap, spd, num;
    cap = (road_cap[r] == 0) ? 64'd1 : 64'(road_cap[r]);
    spd = (road_spd[r] == 0) ? 64'd1 : 64'(road_spd[r]);
    num = 64'(road_len[r]) * (cap + 64'd2 * 64'(road_cnt[r])) * 64'd256;
    return num / (spd * cap);
  endfunction

  task automatic push_beat(int node, logic [1:0] st, logic lst);
    route_beat_t b;
    b.node = gcsp_pkg::ID_W'(node);
    b.status = st;
    b.last = lst;
    expected_route = {expected_route, b};
  endtask

  // Dijkstra over the modelled table, lowest id on a tie
  task automatic predict_route(int start, int goal);
    logic [63:0] path_dist [NODES];
    int          pred [NODES];
    logic        done [NODES];
    logic        seen [NODES];
    int          trail[$];
    int          n, u, v, r, cur;
    logic [63:0] nd;
    n = grid_nodes();
    if (start >= n || goal >= n) begin
      push_beat(0, gcsp_pkg::ST_OUTSIDE, 1'b1);
      return;
    end
    for (int i = 0; i < NODES; i++) begin
      done[i] = 1'b0;
      seen[i] = 1'b0;
      path_dist[i] = '0;
      pred[i] = 0;
    end
    seen[start] = 1'b1;
    pred[start] = start;
    forever begin
      u = -1;
      for (int i = 0; i < n; i++)
        if (seen[i] && !done[i] && (u < 0 || path_dist[i] < path_dist[u])) u = i;
      if (u < 0) break;
      done[u] = 1'b1;
      if (u == goal) break;
      for (int d = 0; d < 4; d++) begin
        r = u * 4 + d;
        v = neighbour(u, 2'(d));
        if (!road_on[r] || v < 0) continue;
        if (done[v]) continue;
        nd = path_dist[u] + travel_time(r);
        if (nd > 64'(DIST_SAT)) nd = 64'(DIST_SAT);
        if (!seen[v] || nd < path_dist[v]) begin
          path_dist[v] = nd;
          pred[v] = u;
          seen[v] = 1'b1;
        end
      end
    end
    if (!done[goal]) begin
      push_beat(0, gcsp_pkg::ST_NOPATH, 1'b1);
      return;
    end
    cur = goal;
    while (trail.size() < NODES) begin
      trail.push_front(cur);
      if (cur == start) break;
      cur = pred[cur];
    end
    foreach (trail[i]) push_beat(trail[i], gcsp_pkg::ST_OK, i == trail.size() - 1);
  endtask

  task automatic apply_item();
    int from, to, r;
    if (in_mon.operation == gcsp_pkg::OP_QUERY) begin
      predict_route(int'(in_mon.path_start), int'(in_mon.path_goal));
      return;
    end
    if (in_mon.operation == gcsp_pkg::OP_CLEAR) begin
      foreach (road_cnt[i]) road_cnt[i] = '0;
      push_beat(0, gcsp_pkg::ST_OK, 1'b1);
      return;
    end
    from = int'(in_mon.road_from);
    to = neighbour(from, in_mon.road_dir);
    if (to < 0) begin
      push_beat(0, gcsp_pkg::ST_OUTSIDE, 1'b1);
      return;
    end
    r = from * 4 + int'(in_mon.road_dir);
    if (in_mon.operation == gcsp_pkg::OP_WRITE) begin
      road_on[r]  = 1'b1;
      road_len[r] = in_mon.road_length;
      road_spd[r] = in_mon.road_speed;
      road_cap[r] = in_mon.road_capacity;
      road_cnt[r] = in_mon.road_cars;
    end else if (road_on[r] && road_cnt[r] != 8'hff) begin
      road_cnt[r] = road_cnt[r] + 8'd1;
    end
    push_beat(0, gcsp_pkg::ST_OK, 1'b1);
  endtask

  // Track registers, input beats and result beats
  always @(posedge clk) begin
    route_beat_t want;
    if (rst) begin
      grid_w = 4'd8;
      grid_h = 4'd8;
      foreach (road_on[i]) begin
        road_on[i] = 1'b0;
        road_cnt[i] = '0;
        road_len[i] = '0;
        road_spd[i] = '0;
        road_cap[i] = '0;
      end
      expected_route.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gcsp_pkg::CFG_GRID_WIDTH) grid_w = cfg_data;
        else grid_h = cfg_data;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_route.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result beat: node %0d status %0d last %0d",
                     out_mon.path_node, out_mon.status, out_mon.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_route.pop_front();
          if (want.node !== out_mon.path_node || want.status !== out_mon.status ||
              want.last !== out_mon.last) begin
            if (fail_count < 10)
              $display("result mismatch: expected node %0d status %0d last %0d, got %0d %0d %0d",
                       want.node, want.status, want.last,
                       out_mon.path_node, out_mon.status, out_mon.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) apply_item();
    end
  end
endmodule

[tb/tb_grid_congestion_shortest_path.sv]
// Testbench top: drives road writes, car updates, clears and path queries, and gives the verdict.
module tb_grid_congestion_shortest_path;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 200000;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [gcsp_pkg::DIM_W-1:0] cfg_data;
  int                         fail_count;
  int                         pending;
  int                         quiet_cycles;
  logic                       hold_sink;
  logic                       stim_done;
  int                         w_now, h_now;

  gcsp_in_if  road_in();
  gcsp_out_if route_out();

  grid_congestion_shortest_path dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(road_in.sink), .out_ch(route_out.source)
  );

  gcsp_route_checker route_check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_mon(road_in.sink), .out_mon(route_out.sink),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sink side: random stalls, or one long hold-off when asked
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    route_out.ready = 1'b0;
    @(posedge clk);
    forever begin
      int n;
      if (hold_sink && !hold_done) begin
        route_out.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_done = 1'b1;
      end
      n = gap_len();
      if (n > 0) begin
        route_out.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      route_out.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || (road_in.valid && road_in.ready) || (route_out.valid && route_out.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, int from, logic [1:0] dir, int len, int spd,
                           int cap, int cars, int start, int goal);
    road_in.valid         <= 1'b1;
    road_in.operation     <= op;
    road_in.road_from     <= gcsp_pkg::ID_W'(from);
    road_in.road_dir      <= dir;
    road_in.road_length   <= gcsp_pkg::LEN_W'(len);
    road_in.road_speed    <= gcsp_pkg::BYTE_W'(spd);
    road_in.road_capacity <= gcsp_pkg::BYTE_W'(cap);
    road_in.road_cars     <= gcsp_pkg::BYTE_W'(cars);
    road_in.path_start    <= gcsp_pkg::ID_W'(start);
    road_in.path_goal     <= gcsp_pkg::ID_W'(goal);
    do @(posedge clk); while (!road_in.ready);
  endtask

  task automatic pause_sender();
    int n;
    n = gap_len();
    if (n > 0) begin
      road_in.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    road_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_grid(int w, int h);
    cfg_we <= 1'b1;
    cfg_index <= gcsp_pkg::CFG_GRID_WIDTH;
    cfg_data <= gcsp_pkg::DIM_W'(w);
    @(posedge clk);
    cfg_index <= gcsp_pkg::CFG_GRID_HEIGHT;
    cfg_data <= gcsp_pkg::DIM_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    w_now = (w == 0) ? 1 : (w > 8 ? 8 : w);
    h_now = (h == 0) ? 1 : (h > 8 ? 8 : h);
  endtask

  // Random mix of road writes, car updates, clears and queries, mostly on grid nodes, with full-range noise mixed in
  task automatic random_item();
    int sel, n, node;
    n = w_now * h_now;
    node = $urandom_range(0, n - 1);
    sel = $urandom_range(0, 99);
    if (sel < 45)
      send_item(gcsp_pkg::OP_WRITE, (sel < 42) ? node : $urandom_range(0, 63), 2'($urandom),
                $urandom_range(0, 4095), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255), 0, 0);
    else if (sel < 65)
      send_item(gcsp_pkg::OP_CAR, node, 2'($urandom), 0, 0, 0, 0, 0, 0);
    else if (sel < 70)
      send_item(gcsp_pkg::OP_CLEAR, $urandom_range(0, 63), 2'($urandom),
                $urandom_range(0, 4095), 0, 0, 0, 0, 0);
    else if (sel < 96)
      send_item(gcsp_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, $urandom_range(0, n - 1),
                $urandom_range(0, n - 1));
    else
      send_item(gcsp_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, $urandom_range(0, 63),
                $urandom_range(0, 63));
    pause_sender();
  endtask

  initial begin
    rst = 1'b1;
    hold_sink = 1'b0;
    stim_done = 1'b0;
    cfg_we = 1'b0;
    cfg_index = gcsp_pkg::CFG_GRID_WIDTH;
    cfg_data = '0;
    w_now = 8;
    h_now = 8;
    road_in.valid = 1'b0;
    road_in.operation = gcsp_pkg::OP_WRITE;
    road_in.road_from = '0;
    road_in.road_dir = gcsp_pkg::DIR_RIGHT;
    road_in.road_length = '0;
    road_in.road_speed = '0;
    road_in.road_capacity = '0;
    road_in.road_cars = '0;
    road_in.path_start = '0;
    road_in.path_goal = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, field extremes, outside cases, each operation
    send_item(gcsp_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 63);
    send_item(gcsp_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 5, 5);
    send_item(gcsp_pkg::OP_CAR, 0, gcsp_pkg::DIR_RIGHT, 0, 0, 0, 0, 0, 0);
    send_item(gcsp_pkg::OP_WRITE, 0, gcsp_pkg::DIR_RIGHT, 4095, 0, 0, 255, 0, 0);
    send_item(gcsp_pkg::OP_WRITE, 1, gcsp_pkg::DIR_DOWN, 0, 255, 255, 0, 0, 0);
    send_item(gcsp_pkg::OP_WRITE, 9, gcsp_pkg::DIR_LEFT, 256, 1, 1, 0, 0, 0);
    send_item(gcsp_pkg::OP_WRITE, 8, gcsp_pkg::DIR_UP, 100, 60, 10, 254, 0, 0);
    send_item(gcsp_pkg::OP_CAR, 8, gcsp_pkg::DIR_UP, 0, 0, 0, 0, 0, 0);
    send_item(gcsp_pkg::OP_CAR, 8, gcsp_pkg::DIR_UP, 0, 0, 0, 0, 0, 0);
    send_item(gcsp_pkg::OP_WRITE, 7, gcsp_pkg::DIR_RIGHT, 1, 1, 1, 1, 0, 0);
    send_item(gcsp_pkg::OP_WRITE, 63, gcsp_pkg::DIR_DOWN, 1, 1, 1, 1, 0, 0);
    send_item(gcsp_pkg::OP_CAR, 56, gcsp_pkg::DIR_LEFT, 0, 0, 0, 0, 0, 0);
    send_item(gcsp_pkg::OP_WRITE, 0, gcsp_pkg::DIR_UP, 1, 1, 1, 1, 0, 0);
    send_item(gcsp_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 9);
    send_item(gcsp_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 9, 0);
    send_item(gcsp_pkg::OP_CLEAR, 63, gcsp_pkg::DIR_UP, 4095, 255, 255, 255, 63, 63);
    send_item(gcsp_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 9);
    drain();

    // Sink holds off while items keep coming, then grid phases
    hold_sink <= 1'b1;
    for (int i = 0; i < 10; i++) random_item();
    drain();

    set_grid(0, 15);
    send_item(gcsp_pkg::OP_WRITE, 0, gcsp_pkg::DIR_DOWN, 10, 10, 10, 0, 0, 0);
    send_item(gcsp_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 8);
    send_item(gcsp_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 9, 0);
    for (int i = 0; i < 25; i++) random_item();
    drain();

    set_grid(3, 2);
    for (int i = 0; i < 30; i++) random_item();
    drain();

    set_grid(8, 8);
    for (int i = 0; i < 25; i++) random_item();
    drain();

    set_grid(15, 1);
    for (int i = 0; i < 20; i++) random_item();
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
